// ----- rtl/sha1_pkg.sv -----
// Shared types and constants of the SHA-1 hash engine.
`timescale 1ns / 1ps

package sha1_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// byte source for the block shift line
	localparam logic [1:0] BSEL_DATA = 2'd0;
	localparam logic [1:0] BSEL_PAD  = 2'd1;
	localparam logic [1:0] BSEL_ZERO = 2'd2;
	localparam logic [1:0] BSEL_LEN  = 2'd3;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [2:0] LAST_WIDX = 3'd4;
	localparam logic [5:0] FILL_FULL = 6'd63;
	localparam logic [5:0] FILL_LEN  = 6'd56;
	localparam logic [6:0] RND_LAST  = 7'd79;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hc3d2e1f0;

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	typedef struct packed {
		logic       shift;      // shift one byte into the block
		logic [1:0] bsel;
		logic       cnt_msg;    // count a message byte
		logic       load_vars;  // a..e <= chain, round count <= 0
		logic       round;
		logic       chain_add;
		logic       out_load;
		logic [2:0] widx;
		logic       clear;      // back to initial hash values
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       rnd_last;
	} sts_t;

endpackage

// ----- rtl/sha1_hash_engine_unit.sv -----
// Top level of the byte-streaming SHA-1 hash engine.
`timescale 1ns / 1ps
//
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+------------------------------------
// byte     | in        | byte_valid / byte_stall  | byte_item   (data_byte, has_byte, last)
// digest   | out       | digest_valid / digest_stall | digest_item (digest_word, word_index, last_word)
//
// Each byte enters the shift line. The 64th byte of a block starts the
// compression: 80 rounds (one round per cycle through the single round
// adder), then the chaining add, input stalled. A last item feeds 0x80,
// zeros and the 8 length bytes one per cycle through the same shift line
// (one or two blocks, paused while a block compresses), then five digest transfers.
// Reset: chaining words to the initial hash values, counts to zero.
// The input is taken again as soon as the fifth word sits in the output register.

module sha1_hash_engine_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  sha1_pkg::in_item_t  byte_item,
	output logic                digest_valid,
	input  logic                digest_stall,
	output sha1_pkg::out_item_t digest_item
);

	sha1_pkg::cmd_t cmd;
	sha1_pkg::sts_t sts;

	// sequencer: handshakes, padding order, round count, word counter
	sha1_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath: block window doubles as the message schedule
	sha1_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (byte_item.data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (digest_item)
	);

endmodule

// ----- rtl/sha1_ctrl.sv -----
// Sequencer of the SHA-1 engine: byte intake, padding, rounds, digest output.
`timescale 1ns / 1ps

module sha1_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  sha1_pkg::in_item_t byte_item,
	output logic               digest_valid,
	input  logic               digest_stall,
	input  sha1_pkg::sts_t     sts,
	output sha1_pkg::cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q, state_n;
	logic       fin_q, fin_n;
	logic       pad_first_q, pad_first_n;
	logic       wrap_q, wrap_n;
	logic [2:0] widx_q, widx_n;
	logic       out_valid_q;
	logic       acc;
	logic       full;
	logic       len_zone;

	assign byte_stall   = (state_q != ST_IDLE);
	assign acc          = byte_valid & ~byte_stall;
	assign digest_valid = out_valid_q;
	assign full         = (sts.fill == sha1_pkg::FILL_FULL);
	assign len_zone     = (sts.fill >= sha1_pkg::FILL_LEN);

	always_comb begin
		state_n     = state_q;
		fin_n       = fin_q;
		pad_first_n = pad_first_q;
		wrap_n      = wrap_q;
		widx_n      = widx_q;
		cmd         = '0;
		cmd.bsel    = sha1_pkg::BSEL_DATA;
		cmd.widx    = widx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (byte_item.has_byte) begin
						cmd.shift   = 1'b1;
						cmd.cnt_msg = 1'b1;
						if (full) begin
							cmd.load_vars = 1'b1;
							state_n       = ST_RND;
						end
					end
					if (byte_item.last) begin
						fin_n       = 1'b1;
						pad_first_n = 1'b1;
						if (!(byte_item.has_byte && full)) begin
							state_n = ST_PAD;
						end
					end
				end
			end
			ST_PAD: begin
				cmd.shift = 1'b1;
				if (pad_first_q) begin
					cmd.bsel    = sha1_pkg::BSEL_PAD;
					pad_first_n = 1'b0;
					// no room left for the length: it goes in one more block
					if (len_zone) begin
						wrap_n = 1'b1;
					end
				end else if (len_zone && !wrap_q) begin
					cmd.bsel = sha1_pkg::BSEL_LEN;
				end else begin
					cmd.bsel = sha1_pkg::BSEL_ZERO;
				end
				if (full) begin
					cmd.load_vars = 1'b1;
					state_n       = ST_RND;
				end
			end
			ST_RND: begin
				cmd.round = 1'b1;
				if (sts.rnd_last) begin
					state_n = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.chain_add = 1'b1;
				if (!fin_q) begin
					state_n = ST_IDLE;
				end else if (pad_first_q || wrap_q) begin
					wrap_n  = 1'b0;
					state_n = ST_PAD;
				end else begin
					widx_n  = '0;
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !digest_stall) begin
					cmd.out_load = 1'b1;
					widx_n       = widx_q + 3'd1;
					if (widx_q == sha1_pkg::LAST_WIDX) begin
						cmd.clear = 1'b1;
						fin_n     = 1'b0;
						state_n   = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= 1'b0;
			pad_first_q <= 1'b0;
			wrap_q      <= 1'b0;
			widx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			fin_q       <= fin_n;
			pad_first_q <= pad_first_n;
			wrap_q      <= wrap_n;
			widx_q      <= widx_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!digest_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/sha1_dp.sv -----
// SHA-1 datapath: block shift line, message schedule, round logic, chaining words.
`timescale 1ns / 1ps

module sha1_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  sha1_pkg::cmd_t      cmd,
	output sha1_pkg::sts_t      sts,
	output sha1_pkg::out_item_t out_item
);

	logic [31:0] blk_q [16];
	logic [31:0] chain_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [5:0]  fill_q;
	logic [60:0] msg_q;
	logic [6:0]  rnd_q;
	logic [7:0]  byte_in;
	logic [63:0] len_shl;
	logic [31:0] w_new;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] tmp;
	logic [31:0] sel_word;

	assign sts.fill     = fill_q;
	assign sts.rnd_last = (rnd_q == sha1_pkg::RND_LAST);

	// length bytes go out most significant first, at fill 56..63
	assign len_shl = {msg_q, 3'b000} << {fill_q[2:0], 3'b000};

	always_comb begin
		unique case (cmd.bsel)
			sha1_pkg::BSEL_DATA: byte_in = data_byte;
			sha1_pkg::BSEL_PAD:  byte_in = sha1_pkg::PAD_BYTE;
			sha1_pkg::BSEL_ZERO: byte_in = 8'h00;
			sha1_pkg::BSEL_LEN:  byte_in = len_shl[63:56];
		endcase
	end

	// window holds W[t..t+15]; append W[t+16]
	always_comb begin
		w_new = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
		w_new = {w_new[30:0], w_new[31]};
	end

	always_comb begin
		priority if (rnd_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = sha1_pkg::K0;
		end else if (rnd_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1_pkg::K1;
		end else if (rnd_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = sha1_pkg::K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1_pkg::K3;
		end
	end

	assign tmp = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + blk_q[0];

	always_comb begin
		unique case (cmd.widx)
			3'd0:    sel_word = chain_q[0];
			3'd1:    sel_word = chain_q[1];
			3'd2:    sel_word = chain_q[2];
			3'd3:    sel_word = chain_q[3];
			3'd4:    sel_word = chain_q[4];
			default: sel_word = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			for (int i = 0; i < 15; i++) begin
				blk_q[i] <= {blk_q[i][23:0], blk_q[i+1][31:24]};
			end
			blk_q[15] <= {blk_q[15][23:0], byte_in};
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				blk_q[i] <= blk_q[i+1];
			end
			blk_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_item.digest_word <= sel_word;
			out_item.word_index  <= cmd.widx;
			out_item.last_word   <= (cmd.widx == sha1_pkg::LAST_WIDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= sha1_pkg::IV0;
			chain_q[1] <= sha1_pkg::IV1;
			chain_q[2] <= sha1_pkg::IV2;
			chain_q[3] <= sha1_pkg::IV3;
			chain_q[4] <= sha1_pkg::IV4;
			fill_q     <= '0;
			msg_q      <= '0;
			rnd_q      <= '0;
		end else begin
			if (cmd.clear) begin
				chain_q[0] <= sha1_pkg::IV0;
				chain_q[1] <= sha1_pkg::IV1;
				chain_q[2] <= sha1_pkg::IV2;
				chain_q[3] <= sha1_pkg::IV3;
				chain_q[4] <= sha1_pkg::IV4;
				fill_q     <= '0;
				msg_q      <= '0;
			end else begin
				if (cmd.chain_add) begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
				end
				if (cmd.shift) begin
					fill_q <= fill_q + 6'd1;
				end
				if (cmd.cnt_msg) begin
					msg_q <= msg_q + 61'd1;
				end
			end
			if (cmd.load_vars) begin
				rnd_q <= '0;
			end else if (cmd.round) begin
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

endmodule

// ----- rtl/sha1_chk.sv -----
// Port-level checker of the SHA-1 engine, bound to the top level.
`timescale 1ns / 1ps

module sha1_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                byte_valid,
	input logic                byte_stall,
	input sha1_pkg::in_item_t  byte_item,
	input logic                digest_valid,
	input logic                digest_stall,
	input sha1_pkg::out_item_t digest_item
);

	// stalled digest word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && digest_stall |=> digest_valid && $stable(digest_item))
		else $error("digest word changed while stalled");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (digest_item.last_word ==
			(digest_item.word_index == sha1_pkg::LAST_WIDX)))
		else $error("last_word does not match word_index");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> (digest_item.word_index <= sha1_pkg::LAST_WIDX))
		else $error("word_index out of range");

	// input blocked while earlier digest words are still going out
	a_emit_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_item.last_word |-> byte_stall)
		else $error("input open during digest output");

	a_last_pads: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall && byte_item.last |=> byte_stall)
		else $error("no padding after last transfer");

endmodule

bind sha1_hash_engine_unit sha1_chk u_sha1_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_stall   (byte_stall),
	.byte_item    (byte_item),
	.digest_valid (digest_valid),
	.digest_stall (digest_stall),
	.digest_item  (digest_item)
);

// ----- test/tb_sha1_hash_engine_unit.sv -----
// Self-checking testbench of the byte-streaming SHA-1 hash engine.
`timescale 1ns / 1ps

module tb_sha1_hash_engine_unit;

	typedef logic [31:0] word_t;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 300;
	localparam int RANDOM_ITEMS  = 215;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                byte_valid   = 1'b0;
	logic                byte_stall;
	sha1_pkg::in_item_t  byte_item    = '0;
	logic                digest_valid;
	logic                digest_stall = 1'b0;
	sha1_pkg::out_item_t digest_item;

	bit quiet       = 1'b0;  // set for stretches with no idling on either side
	int errors      = 0;
	int idle_cycles = 0;

	// Predicted hash state, advanced on every accepted input transfer
	word_t               chain_h[5];
	word_t               msg_block[16];
	logic [5:0]          block_fill;
	logic [60:0]         msg_len;
	sha1_pkg::out_item_t digest_q[$];

	sha1_hash_engine_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_item  (digest_item)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// SHA-1 predictor
	// ------------------------------------------------------------------
	function automatic word_t rol(input word_t v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void hash_restart();
		chain_h[0] = sha1_pkg::IV0;
		chain_h[1] = sha1_pkg::IV1;
		chain_h[2] = sha1_pkg::IV2;
		chain_h[3] = sha1_pkg::IV3;
		chain_h[4] = sha1_pkg::IV4;
		block_fill = '0;
		msg_len    = '0;
	endfunction

	function automatic void compress_block();
		word_t w[16];
		word_t a, b, c, d, e, f, k, tmp;
		int t;
		for (t = 0; t < 16; t++)
			w[t] = msg_block[t];
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (t = 0; t < 80; t++) begin
			if (t >= 16)
				w[t % 16] = rol(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^
					w[(t + 2) % 16] ^ w[t % 16], 1);
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = sha1_pkg::K0;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = sha1_pkg::K1;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1_pkg::K2;
			end else begin
				f = b ^ c ^ d;
				k = sha1_pkg::K3;
			end
			tmp = rol(a, 5) + f + e + k + w[t % 16];
			e = d;
			d = c;
			c = rol(b, 30);
			b = a;
			a = tmp;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endfunction

	// big-endian byte placement within the 16-word block
	function automatic void place_byte(input int pos, input logic [7:0] val);
		msg_block[pos[5:2]][8 * (3 - pos[1:0]) +: 8] = val;
	endfunction

	function automatic void predict_digest(input sha1_pkg::in_item_t it);
		logic [63:0]         bit_len;
		sha1_pkg::out_item_t o;
		int p;
		int i;
		if (it.has_byte) begin
			place_byte(int'(block_fill), it.data_byte);
			block_fill++;
			msg_len++;
			if (block_fill == 0)
				compress_block();
		end
		if (!it.last)
			return;

		// padding: 0x80, zeros, then the 64-bit bit count
		bit_len = {msg_len, 3'b000};
		place_byte(int'(block_fill), sha1_pkg::PAD_BYTE);
		for (p = block_fill + 1; p < 64; p++)
			place_byte(p, 8'h00);
		if (block_fill >= sha1_pkg::FILL_LEN) begin
			compress_block();
			for (p = 0; p < 16; p++)
				msg_block[p] = '0;
		end
		msg_block[14] = bit_len[63:32];
		msg_block[15] = bit_len[31:0];
		compress_block();

		for (i = 0; i < 5; i++) begin
			o.digest_word = chain_h[i];
			o.word_index  = 3'(i);
			o.last_word   = (3'(i) == sha1_pkg::LAST_WIDX);
			digest_q.push_back(o);
		end
		hash_restart();
	endfunction

	// ------------------------------------------------------------------
	// Output side: random stall, result check, watchdog
	// ------------------------------------------------------------------
	always @(negedge clk)
		digest_stall <= !quiet && ($urandom_range(99) < 8);

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		sha1_pkg::out_item_t want;
		if (arst_n && digest_valid && !digest_stall) begin
			if (digest_q.size() == 0) begin
				report_mismatch($sformatf("digest word %h with nothing outstanding",
					digest_item.digest_word));
			end else begin
				want = digest_q.pop_front();
				if (digest_item.digest_word !== want.digest_word)
					report_mismatch($sformatf("digest_word %h, predicted %h (index %0d)",
						digest_item.digest_word, want.digest_word, want.word_index));
				if (digest_item.word_index !== want.word_index)
					report_mismatch($sformatf("word_index %0d, predicted %0d",
						digest_item.word_index, want.word_index));
				if (digest_item.last_word !== want.last_word)
					report_mismatch($sformatf("last_word %b, predicted %b (index %0d)",
						digest_item.last_word, want.last_word, want.word_index));
			end
		end
	end

	// ends the run when neither channel completes a transfer for too long
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (digest_valid && !digest_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sha1_hash_engine_unit: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	// Valid stays high after a transfer so that back-to-back items need no
	// bubble; end_phase drops it.
	task automatic send_item(input logic [7:0] data, input logic has, input logic fin);
		sha1_pkg::in_item_t it;
		int gap;
		it.data_byte = data;
		it.has_byte  = has;
		it.last      = fin;
		if (!quiet && $urandom_range(99) < 8) begin
			gap = $urandom_range(2, 0);
			@(negedge clk);
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_item  <= it;
		do
			@(posedge clk);
		while (byte_stall);
		predict_digest(it);
	endtask

	// One message of len random bytes. The end comes either on the last
	// byte or as a separate empty item; noise sprinkles ignored items in.
	task automatic send_message(input int len, input bit empty_end, input bit noise);
		int i;
		for (i = 0; i < len; i++) begin
			if (noise && $urandom_range(99) < 6)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(255)), 1'b1, !empty_end && (i == len - 1));
		end
		if (empty_end || len == 0)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic end_phase(input int settle);
		@(negedge clk);
		byte_valid <= 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// ignored item, then the empty message, twice in a row
	task automatic test_empty_message();
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		end_phase(20);
	endtask

	// "abc" with the end flag on the byte itself
	task automatic test_abc();
		send_item("a", 1'b1, 1'b0);
		send_item("b", 1'b1, 1'b0);
		send_item("c", 1'b1, 1'b1);
		end_phase(20);
	endtask

	// data extremes, an ignored item mid-message and an empty closing item
	task automatic test_byte_extremes();
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		end_phase(20);
	endtask

	// padding around the block edge, no idling on either side:
	// 55 bytes fit the length in one block, 56 need a second one,
	// the 64th byte with the end flag compresses first, then pads.
	task automatic test_block_boundaries();
		quiet = 1'b1;
		send_message(55, 1'b0, 1'b0);
		send_message(56, 1'b1, 1'b0);
		send_message(64, 1'b0, 1'b0);
		end_phase(20);
		quiet = 1'b0;
	endtask

	// mostly short messages, many near the block edges, a few multi-block
	task automatic test_random_messages();
		int sent;
		int len;
		int r;
		bit empty_end;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 50)
				len = $urandom_range(12, 0);
			else if (r < 80)
				len = $urandom_range(72, 52);
			else if (r < 95)
				len = $urandom_range(51, 13);
			else
				len = $urandom_range(140, 100);
			empty_end = ($urandom_range(3) == 0);
			send_message(len, empty_end, 1'b1);
			sent += len + ((empty_end || len == 0) ? 1 : 0);
		end
		end_phase(20);
	endtask

	initial begin
		hash_restart();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_message();
		test_abc();
		test_byte_extremes();
		test_block_boundaries();
		test_random_messages();

		end_phase(SETTLE_CYCLES);
		if (errors == 0)
			$display("sha1_hash_engine_unit: match");
		else
			$display("sha1_hash_engine_unit: mismatch");
		$finish;
	end

endmodule
